### rtl/nonuniform_ring_ca_evaluator_top_assert.svh
// Assertion macros for the non-uniform ring CA evaluator.
`ifndef NONUNIFORM_RING_CA_EVALUATOR_TOP_ASSERT_SVH
`define NONUNIFORM_RING_CA_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NRCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NRCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nrca_pkg.sv
// Shared constants, types and functions of the ring CA evaluator.
package nrca_pkg;

  parameter int CELLS     = 32;
  parameter int RULESETS  = 4;
  parameter int SEL_W     = 2;
  parameter int RULE_W    = RULESETS * 8;
  parameter int RIDX_W    = $clog2(RULE_W) < 3 ? 3 : $clog2(RULE_W);
  parameter int MAP_W     = SEL_W * CELLS;
  parameter int STEP_W    = 8;
  parameter int FIELD_W   = 32;
  parameter int CNT_FW    = 6;
  parameter int CNT_W     = $clog2(CELLS + 1);
  parameter int NGRP      = (CELLS + 7) / 8;
  parameter int DIFF_W    = NGRP * 8;
  parameter int IN_TW     = 2 * FIELD_W;
  parameter int OUT_TW    = ((FIELD_W + CNT_FW + 7) / 8) * 8;
  parameter int CFG_IDX_W = 3;
  parameter int CFG_DW    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULES   = 3'd0,
    CFG_MAP     = 3'd1,
    CFG_BGND    = 3'd2,
    CFG_IN_MASK = 3'd3,
    CFG_OUT_MASK = 3'd4,
    CFG_STEPS   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
  } status_t;

  // Next value of one cell from its neighborhood code and ruleset selector.
  function automatic logic rule_bit(input logic [RULE_W-1:0] rules,
                                    input logic [SEL_W-1:0]  sel,
                                    input logic [2:0]        v);
    logic [SEL_W-1:0]  sel_eff;
    logic [RIDX_W-1:0] pos;
    sel_eff = sel;
    if ({1'b0, sel} >= (SEL_W+1)'(RULESETS)) begin
      sel_eff = '0;
    end
    pos = RIDX_W'({sel_eff, ~v});
    return rules[pos];
  endfunction

endpackage

### rtl/nrca_ctrl.sv
// Sequencer: accept, generation count, mismatch count and result hand-off.
module nrca_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  nrca_pkg::status_t status_i,
  output nrca_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_COUNT,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [nrca_pkg::STEP_W-1:0] steps_q;
  logic                        in_ready_q;
  logic                        out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i && in_ready_q;
    cmd_o.step  = (state_q == ST_RUN) && (steps_q != '0);
    cmd_o.count = (state_q == ST_COUNT);
    cmd_o.emit  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            in_ready_q <= 1'b0;
            steps_q    <= status_i.step_count;
            state_q    <= ST_RUN;
          end else begin
            in_ready_q <= 1'b1;
          end
        end
        ST_RUN: begin
          if (cmd_o.step) begin
            steps_q <= steps_q - 1'b1;
          end else begin
            state_q <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd_o.emit) begin
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

### rtl/nrca_dp.sv
// Datapath: config registers, cell row, per-cell rule lookup, mismatch count.
module nrca_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nrca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nrca_pkg::CFG_DW-1:0]       cfg_wdata_i,
  input  logic [nrca_pkg::FIELD_W-1:0]      operand_cells_i,
  input  logic [nrca_pkg::FIELD_W-1:0]      expected_cells_i,
  input  nrca_pkg::cmd_t                    cmd_i,
  output nrca_pkg::status_t                 status_o,
  output logic [nrca_pkg::FIELD_W-1:0]      final_row_o,
  output logic [nrca_pkg::CNT_FW-1:0]       mismatch_count_o
);

  logic [nrca_pkg::RULE_W-1:0] rules_q;
  logic [nrca_pkg::MAP_W-1:0]  map_q;
  logic [nrca_pkg::CELLS-1:0]  bgnd_q;
  logic [nrca_pkg::CELLS-1:0]  in_mask_q;
  logic [nrca_pkg::CELLS-1:0]  out_mask_q;
  logic [nrca_pkg::STEP_W-1:0] steps_q;

  logic [nrca_pkg::CELLS-1:0]  row_q, row_d;
  logic [nrca_pkg::CELLS-1:0]  exp_q;
  logic [nrca_pkg::CELLS-1:0]  init_row;
  logic [nrca_pkg::CELLS-1:0]  next_row;
  logic [nrca_pkg::DIFF_W-1:0] diff;
  logic [3:0]                  part_d [nrca_pkg::NGRP];
  logic [3:0]                  part_q [nrca_pkg::NGRP];
  logic [nrca_pkg::CNT_W-1:0]  total;
  logic [nrca_pkg::FIELD_W-1:0] out_row_q;
  logic [nrca_pkg::CNT_FW-1:0]  out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q    <= '0;
      map_q      <= '0;
      bgnd_q     <= '0;
      in_mask_q  <= '0;
      out_mask_q <= '0;
      steps_q    <= nrca_pkg::STEP_W'(16);
    end else if (cfg_we_i) begin
      unique case (nrca_pkg::cfg_idx_e'(cfg_index_i))
        nrca_pkg::CFG_RULES:    rules_q    <= cfg_wdata_i[nrca_pkg::RULE_W-1:0];
        nrca_pkg::CFG_MAP:      map_q      <= cfg_wdata_i[nrca_pkg::MAP_W-1:0];
        nrca_pkg::CFG_BGND:     bgnd_q     <= cfg_wdata_i[nrca_pkg::CELLS-1:0];
        nrca_pkg::CFG_IN_MASK:  in_mask_q  <= cfg_wdata_i[nrca_pkg::CELLS-1:0];
        nrca_pkg::CFG_OUT_MASK: out_mask_q <= cfg_wdata_i[nrca_pkg::CELLS-1:0];
        nrca_pkg::CFG_STEPS:    steps_q    <= cfg_wdata_i[nrca_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign status_o.step_count = steps_q;

  assign init_row = (operand_cells_i[nrca_pkg::CELLS-1:0] & in_mask_q)
                  | (bgnd_q & ~in_mask_q);

  // One generation of every cell at once, ring wraps at both ends.
  always_comb begin
    logic       left;
    logic       right;
    for (int i = 0; i < nrca_pkg::CELLS; i++) begin
      left  = (i == 0) ? row_q[nrca_pkg::CELLS-1] : row_q[(i == 0) ? 0 : i - 1];
      right = (i == nrca_pkg::CELLS - 1) ? row_q[0]
                                         : row_q[(i == nrca_pkg::CELLS - 1) ? 0 : i + 1];
      next_row[i] = nrca_pkg::rule_bit(rules_q, map_q[nrca_pkg::SEL_W*i +: nrca_pkg::SEL_W],
                                       {left, row_q[i], right});
    end
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.load) begin
      row_d = init_row;
    end else if (cmd_i.step) begin
      row_d = next_row;
    end
  end

  // Mismatch count, first stage: one partial count per byte of cells.
  assign diff = nrca_pkg::DIFF_W'((row_q ^ exp_q) & out_mask_q);

  always_comb begin
    for (int g = 0; g < nrca_pkg::NGRP; g++) begin
      part_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        part_d[g] = part_d[g] + 4'(diff[g*8 + b]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < nrca_pkg::NGRP; g++) begin
      total = total + nrca_pkg::CNT_W'(part_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (cmd_i.load) begin
      exp_q <= expected_cells_i[nrca_pkg::CELLS-1:0];
    end
    if (cmd_i.count) begin
      part_q <= part_d;
    end
    if (cmd_i.emit) begin
      out_row_q <= nrca_pkg::FIELD_W'(row_q);
      out_cnt_q <= nrca_pkg::CNT_FW'(total);
    end
  end

  assign final_row_o      = out_row_q;
  assign mismatch_count_o = out_cnt_q;

endmodule

### rtl/nonuniform_ring_ca_evaluator_top.sv
// Top level of the non-uniform ring cellular automaton evaluator.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   operand_cells, expected_cells
//   m_axis    out  m_axis_tvalid/m_axis_tready   final_row, mismatch_count
//   cfg       in   cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// From accept to result an item passes the run state, one generation per cycle
// over all cells, then a state that leaves the run, a partial-count state and
// the output register, which waits while an earlier result is untaken. One item
// is in work at a time; the next is accepted the cycle after the result is registered,
// even while that result still waits on m_axis_tready.
// Reset is asynchronous and active low; no clearing pass is needed.
module nonuniform_ring_ca_evaluator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [nrca_pkg::IN_TW-1:0]         s_axis_tdata,  // operand_cells, expected_cells
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [nrca_pkg::OUT_TW-1:0]        m_axis_tdata,  // final_row, mismatch_count, pad
  input  logic                               cfg_we_i,
  input  logic [nrca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nrca_pkg::CFG_DW-1:0]        cfg_wdata_i
);

  nrca_pkg::cmd_t               cmd;
  nrca_pkg::status_t            status;
  logic [nrca_pkg::FIELD_W-1:0] final_row;
  logic [nrca_pkg::CNT_FW-1:0]  mismatch_count;

  nrca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nrca_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operand_cells_i  (s_axis_tdata[nrca_pkg::FIELD_W-1:0]),
    .expected_cells_i (s_axis_tdata[nrca_pkg::IN_TW-1:nrca_pkg::FIELD_W]),
    .cmd_i            (cmd),
    .status_o         (status),
    .final_row_o      (final_row),
    .mismatch_count_o (mismatch_count)
  );

  assign m_axis_tdata = nrca_pkg::OUT_TW'({mismatch_count, final_row});

`include "nonuniform_ring_ca_evaluator_top_assert.svh"

  `NRCA_ASSERT_NOW(a_no_accept_while_busy, cmd.step || cmd.count, !s_axis_tready, "accept while busy")
  `NRCA_ASSERT_NOW(a_emit_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready, "result overwritten")
  `NRCA_ASSERT_NEXT(a_one_item_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second accept")

endmodule

### verif/testbench.sv
// Self-checking testbench for the non-uniform ring CA evaluator.
module testbench;
  import nrca_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] expected_cells;
    logic [FIELD_W-1:0] operand_cells;
  } cells_item_t;

  typedef struct packed {
    logic [CNT_FW-1:0]  mismatch_count;
    logic [FIELD_W-1:0] final_row;
  } ca_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_TW-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]    m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0]    cfg_wdata_i = '0;

  // shadow copy of the configuration registers
  logic [RULE_W-1:0]  rules_r = '0;
  logic [MAP_W-1:0]   map_r = '0;
  logic [FIELD_W-1:0] bgnd_r = '0;
  logic [FIELD_W-1:0] in_mask_r = '0;
  logic [FIELD_W-1:0] out_mask_r = '0;
  logic [STEP_W-1:0]  steps_r = 8'd16;

  cells_item_t pending_q[$];
  ca_result_t  predicted_q[$];
  cells_item_t tx_cur;
  int          tx_wait = 0;
  int          rx_wait = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  nonuniform_ring_ca_evaluator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // operand_cells, expected_cells
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // final_row, mismatch_count, pad
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Runs the ring for steps_r generations and counts output-cell mismatches.
  function automatic ca_result_t evolve_row(input logic [FIELD_W-1:0] operand,
                                            input logic [FIELD_W-1:0] expected);
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] nxt;
    logic [2:0]         v;
    int                 sel;
    int                 cnt;
    ca_result_t         res;
    row = '0;
    cnt = 0;
    for (int i = 0; i < CELLS; i++) begin
      row[i] = in_mask_r[i] ? operand[i] : bgnd_r[i];
    end
    for (int s = 0; s < int'(steps_r); s++) begin
      nxt = '0;
      for (int i = 0; i < CELLS; i++) begin
        v = {row[(i + CELLS - 1) % CELLS], row[i], row[(i + 1) % CELLS]};
        sel = int'(map_r[2*i +: 2]);
        if (sel >= RULESETS) begin
          sel = 0;
        end
        nxt[i] = rules_r[sel * 8 + 7 - int'(v)];
      end
      row = nxt;
    end
    for (int i = 0; i < CELLS; i++) begin
      if (out_mask_r[i] && (row[i] != expected[i])) begin
        cnt++;
      end
    end
    res.final_row = row;
    res.mismatch_count = CNT_FW'(cnt);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h5555_5555;
      3: return 32'hAAAA_AAAA;
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_RULES:    rules_r = val[RULE_W-1:0];
      CFG_MAP:      map_r = val[MAP_W-1:0];
      CFG_BGND:     bgnd_r = val[FIELD_W-1:0];
      CFG_IN_MASK:  in_mask_r = val[FIELD_W-1:0];
      CFG_OUT_MASK: out_mask_r = val[FIELD_W-1:0];
      CFG_STEPS:    steps_r = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits beyond each register but the map carry junk; a spare index is hit last
  task automatic load_ca_config(input logic [31:0] rules, input logic [63:0] map,
                                input logic [31:0] bgnd, input logic [31:0] in_mask,
                                input logic [31:0] out_mask, input logic [7:0] steps);
    write_reg(CFG_RULES, {$urandom, rules});
    write_reg(CFG_MAP, map);
    write_reg(CFG_BGND, {$urandom, bgnd});
    write_reg(CFG_IN_MASK, {$urandom, in_mask});
    write_reg(CFG_OUT_MASK, {$urandom, out_mask});
    write_reg(CFG_STEPS, {$urandom, 24'($urandom), steps});
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, {$urandom, $urandom});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_item(input logic [31:0] op, input logic [31:0] ex);
    pending_q.push_back(cells_item_t'{expected_cells: ex, operand_cells: op});
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_q.push_back(evolve_row(tx_cur.operand_cells, tx_cur.expected_cells));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0 || pending_q.size() == 0) begin
          if (tx_wait > 0) begin
            tx_wait--;
          end
          s_axis_tvalid <= 1'b0;
        end else begin
          tx_cur = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= tx_cur;
          tx_wait = idle_len(tx_calm);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    ca_result_t want;
    ca_result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[FIELD_W+CNT_FW-1:0];
        if (predicted_q.size() == 0) begin
          flag_error($sformatf("unexpected beat: row %h count %0d",
                               got.final_row, got.mismatch_count));
        end else begin
          want = predicted_q.pop_front();
          if (got.final_row !== want.final_row) begin
            flag_error($sformatf("final_row: expected %h got %h",
                                 want.final_row, got.final_row));
          end
          if (got.mismatch_count !== want.mismatch_count) begin
            flag_error($sformatf("mismatch_count: expected %0d got %0d",
                                 want.mismatch_count, got.mismatch_count));
          end
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_wait = idle_len(rx_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          sent;
    int          n;
    logic [31:0] op;
    logic [31:0] ex;
    logic [7:0]  steps;
    ca_result_t  pred;
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: 16 generations, all rules zero
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item($urandom, $urandom);
    wait_idle();

    // zero generations, every cell an input and an output
    load_ca_config($urandom, {$urandom, $urandom}, 32'h0, '1, '1, 8'd0);
    add_item(32'h0, 32'hFFFF_FFFF);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(32'h5555_5555, 32'hAAAA_AAAA);
    add_item(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    add_item($urandom, $urandom);
    wait_idle();

    // background only, all-ones rules
    load_ca_config('1, '1, '1, 32'h0, 32'h5555_5555, 8'd1);
    add_item(32'h0, 32'h0);
    add_item(32'hFFFF_FFFF, 32'hAAAA_AAAA);
    add_item($urandom, $urandom);
    wait_idle();

    // longest run
    load_ca_config(32'h0, 64'h0, $urandom, $urandom, '1, 8'hFF);
    add_item($urandom, $urandom);
    add_item(32'hFFFF_FFFF, 32'h0);
    add_item(32'h0, 32'h0);
    wait_idle();

    // four distinct rulesets interleaved over the ring
    load_ca_config(32'hE196_3C5A, 64'hE4E4_E4E4_1B1B_1B1B, $urandom, $urandom, $urandom, 8'd1);
    add_item(32'h0000_0001, $urandom);
    add_item(32'h8000_0000, $urandom);
    add_item($urandom, $urandom);
    add_item($urandom, $urandom);
    wait_idle();
    write_reg(CFG_STEPS, {56'h0, 8'd2});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    add_item(32'h0000_0001, $urandom);
    add_item($urandom, $urandom);
    add_item($urandom, $urandom);
    wait_idle();

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: steps = 8'd0;
        1: steps = 8'd1;
        2: steps = 8'hFF;
        default: steps = 8'($urandom_range(2, 24));
      endcase
      load_ca_config(pick_word(), {pick_word(), pick_word()}, pick_word(), pick_word(),
                     pick_word(), steps);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = (steps == 8'hFF) ? 8 : $urandom_range(30, 70);
      for (int k = 0; k < n; k++) begin
        op = $urandom;
        ex = $urandom;
        if ($urandom_range(0, 1)) begin
          pred = evolve_row(op, ex);
          ex = pred.final_row ^ ($urandom & $urandom & $urandom);
        end
        add_item(op, ex);
      end
      sent += n;
      wait_idle();
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
